@@ rtl/srsw_pkg.sv @@
package srsw_pkg;

	localparam int MAX_SLOTS  = 32;
	localparam int MAX_LENGTH = 1500;

	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 11;
	localparam int KIND_W     = 3;
	localparam int WS_W       = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// The modulo unit retires this many dividend bits per cycle.
	localparam int MOD_STEP   = 8;
	localparam int MOD_CYC    = SEQ_W / MOD_STEP;
	localparam int MOD_CNT_W  = $clog2(MOD_CYC);

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 1'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_START   = 3'd0,
		KIND_SEND    = 3'd1,
		KIND_LOOKUP  = 3'd2,
		KIND_LOWEST  = 3'd3,
		KIND_RELEASE = 3'd4
	} srsw_kind_t;

	typedef struct packed {
		logic capture;
		logic mod_item;
		logic mod_scan;
		logic rd_slot;
		logic rd_scan;
		logic do_start;
		logic do_send;
		logic look_eval;
		logic scan_init;
		logic scan_eval;
		logic scan_end;
		logic load_out;
	} srsw_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              mod_done;
		logic              scan_last;
		logic              out_free;
	} srsw_status_t;

endpackage

@@ rtl/selective_repeat_send_window.sv @@
// Sender window of a selective-repeat link. Each word on the input channel is one
// operation (start, send, lookup, lowest or release) and produces exactly one result
// word; the slot field indexes an external packet buffer. The block works on one word
// at a time. A send and a lookup wait for their slot, since the slot is seq modulo
// the window size and the shared modulo unit retires 8 bits per cycle. Lowest and
// release walk every slot of the window through that same unit and the slot
// memory's registered read port. A finished result sits in an output register, so the
// next word is taken while it waits. Write the configuration only while the block is
// idle.
module selective_repeat_send_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [srsw_pkg::KIND_W-1:0]     kind,
	input  logic [srsw_pkg::SEQ_W-1:0]      seq,
	input  logic [srsw_pkg::LEN_W-1:0]      length,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [srsw_pkg::SLOT_W-1:0]     slot,
	output logic [srsw_pkg::SEQ_W-1:0]      found_seq,
	output logic [srsw_pkg::LEN_W-1:0]      found_length,
	output logic                            can_send,
	output logic                            all_acked
);
	import srsw_pkg::*;

	srsw_cmd_t    cmd;
	srsw_status_t status;

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	srsw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.seq          (seq),
		.length       (length),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.hit          (hit),
		.slot         (slot),
		.found_seq    (found_seq),
		.found_length (found_length),
		.can_send     (can_send),
		.all_acked    (all_acked)
	);

endmodule

@@ rtl/srsw_mod.sv @@
module srsw_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [srsw_pkg::SEQ_W-1:0] dividend,
	input  logic [srsw_pkg::WS_W-1:0]  divisor,
	output logic                       done,
	output logic [srsw_pkg::SLOT_W-1:0] rem
);
	import srsw_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SEQ_W-1:0]     dvd_q;
	logic [WS_W-1:0]      dvs_q;
	logic [WS_W-1:0]      rem_q;
	logic [WS_W-1:0]      rem_nxt;

	// Restoring remainder, MOD_STEP bits per cycle. The partial remainder stays
	// below the divisor, so doubling it never overflows WS_W bits.
	always_comb begin
		rem_nxt = rem_q;
		for (int k = 0; k < MOD_STEP; k++) begin
			rem_nxt = {rem_nxt[WS_W-2:0], dvd_q[SEQ_W-1-k]};
			if (rem_nxt >= dvs_q) begin
				rem_nxt = rem_nxt - dvs_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_STEP;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[SLOT_W-1:0];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dvs_q))
		else $error("remainder not below divisor");

endmodule

@@ rtl/srsw_dp.sv @@
module srsw_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [srsw_pkg::KIND_W-1:0]     kind,
	input  logic [srsw_pkg::SEQ_W-1:0]      seq,
	input  logic [srsw_pkg::LEN_W-1:0]      length,
	input  logic                            cfg_write,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  srsw_pkg::srsw_cmd_t             cmd,
	output srsw_pkg::srsw_status_t          status,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            hit,
	output logic [srsw_pkg::SLOT_W-1:0]     slot,
	output logic [srsw_pkg::SEQ_W-1:0]      found_seq,
	output logic [srsw_pkg::LEN_W-1:0]      found_length,
	output logic                            can_send,
	output logic                            all_acked
);
	import srsw_pkg::*;

	// Configuration.
	logic [WS_W-1:0]   ws_q;
	logic [SEQ_W-1:0]  start_seq_q;
	logic [WS_W-1:0]   sz;

	// Captured word.
	logic [KIND_W-1:0] item_kind_q;
	logic [SEQ_W-1:0]  item_seq_q;
	logic [LEN_W-1:0]  item_len_q;
	logic [LEN_W-1:0]  len_sat;

	// Window edges and slot marks.
	logic [SEQ_W-1:0]     lower_q;
	logic [SEQ_W-1:0]     current_q;
	logic [SEQ_W-1:0]     upper_q;
	logic [MAX_SLOTS-1:0] used_q;

	// Slot storage.
	logic [SEQ_W-1:0]     seq_mem [MAX_SLOTS];
	logic [LEN_W-1:0]     len_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] written_q;
	logic [SLOT_W-1:0]    rd_addr;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_addr_q;
	logic [SEQ_W-1:0]     rd_seq_q;
	logic [LEN_W-1:0]     rd_len_q;
	logic                 rd_used;

	// Modulo unit.
	logic              mod_start;
	logic [SEQ_W-1:0]  mod_dividend;
	logic              mod_done;
	logic [SLOT_W-1:0] mod_rem;

	// Scan.
	logic [SLOT_W-1:0] idx_q;
	logic              best_found_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic              is_release;
	logic [SEQ_W-1:0]  hi;
	logic              maps;
	logic              ge_lo;
	logic              lt_hi;
	logic              lt_cur;
	logic              clr;
	logic              live;
	logic              better;
	logic [SEQ_W-1:0]  new_lower;

	// Result under construction and output register.
	logic              res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [SEQ_W-1:0]  res_fseq_q;
	logic [LEN_W-1:0]  res_flen_q;
	logic              out_valid_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SEQ_W-1:0]  found_seq_q;
	logic [LEN_W-1:0]  found_length_q;
	logic              can_send_q;
	logic              all_acked_q;

	always_comb begin
		if (ws_q == '0) begin
			sz = WS_W'(1);
		end else if (ws_q > WS_W'(MAX_SLOTS)) begin
			sz = WS_W'(MAX_SLOTS);
		end else begin
			sz = ws_q;
		end
	end

	assign len_sat = (item_len_q > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : item_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WS_W'(MAX_SLOTS);
			start_seq_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WINDOW_SIZE: ws_q        <= cfg_data[WS_W-1:0];
				CFG_START_SEQ:   start_seq_q <= cfg_data[SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_kind_q <= KIND_START;
		end else if (cmd.capture) begin
			item_kind_q <= kind;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_seq_q <= seq;
			item_len_q <= length;
		end
	end

	assign mod_start    = cmd.mod_item | cmd.mod_scan;
	assign mod_dividend = cmd.mod_scan ? rd_seq_q : item_seq_q;

	srsw_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (sz),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign rd_addr = cmd.rd_scan ? idx_q : mod_rem;
	assign rd_en   = cmd.rd_scan | cmd.rd_slot;

	// Slots that were never written read as zero, as after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (cmd.do_send) begin
			written_q[mod_rem] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_send) begin
			seq_mem[mod_rem] <= item_seq_q;
			len_mem[mod_rem] <= len_sat;
		end
		if (rd_en) begin
			rd_seq_q  <= written_q[rd_addr] ? seq_mem[rd_addr] : '0;
			rd_len_q  <= written_q[rd_addr] ? len_mem[rd_addr] : '0;
			rd_addr_q <= rd_addr;
		end
	end

	assign rd_used = used_q[rd_addr_q];

	// A slot counts only when its stored sequence maps to it under the present size.
	assign is_release = (item_kind_q == KIND_RELEASE);
	assign hi         = (item_seq_q < current_q) ? item_seq_q : current_q;
	assign maps       = (mod_rem == rd_addr_q);
	assign ge_lo      = (rd_seq_q >= lower_q);
	assign lt_hi      = (rd_seq_q < hi);
	assign lt_cur     = (rd_seq_q < current_q);
	assign clr        = is_release & maps & ge_lo & lt_hi;
	assign live       = rd_used & ~clr & maps & ge_lo & lt_cur;
	assign better     = live & (~best_found_q | (rd_seq_q < best_seq_q));
	assign new_lower  = best_found_q ? best_seq_q : current_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.do_start) begin
			used_q <= '0;
		end else if (cmd.do_send) begin
			used_q[mod_rem] <= 1'b1;
		end else if (cmd.scan_eval && clr) begin
			used_q[rd_addr_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q   <= '0;
			current_q <= '0;
			upper_q   <= SEQ_W'(MAX_SLOTS);
		end else if (cmd.do_start) begin
			lower_q   <= start_seq_q;
			current_q <= start_seq_q;
			upper_q   <= start_seq_q + SEQ_W'(sz);
		end else if (cmd.do_send) begin
			if (item_seq_q == current_q) begin
				current_q <= current_q + 1'b1;
			end
		end else if (cmd.scan_end && is_release) begin
			lower_q <= new_lower;
			upper_q <= new_lower + SEQ_W'(sz);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_init) begin
			idx_q        <= '0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_eval) begin
			idx_q <= idx_q + 1'b1;
			if (better) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_seq_q  <= '0;
			best_len_q  <= '0;
			best_slot_q <= '0;
		end else if (cmd.scan_eval && better) begin
			best_seq_q  <= rd_seq_q;
			best_len_q  <= rd_len_q;
			best_slot_q <= rd_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_hit_q  <= 1'b0;
			res_slot_q <= '0;
			res_fseq_q <= '0;
			res_flen_q <= '0;
		end else if (cmd.do_send) begin
			res_slot_q <= mod_rem;
			res_fseq_q <= item_seq_q;
			res_flen_q <= len_sat;
		end else if (cmd.look_eval) begin
			res_slot_q <= mod_rem;
			if (rd_used && (rd_seq_q == item_seq_q)) begin
				res_hit_q  <= 1'b1;
				res_fseq_q <= item_seq_q;
				res_flen_q <= rd_len_q;
			end
		end else if (cmd.scan_end && (item_kind_q == KIND_LOWEST)) begin
			res_hit_q  <= best_found_q;
			res_slot_q <= best_slot_q;
			res_fseq_q <= best_seq_q;
			res_flen_q <= best_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.load_out | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit_q          <= res_hit_q;
			slot_q         <= res_slot_q;
			found_seq_q    <= res_fseq_q;
			found_length_q <= res_flen_q;
			can_send_q     <= (current_q < upper_q);
			all_acked_q    <= (lower_q == current_q);
		end
	end

	assign status.kind      = item_kind_q;
	assign status.mod_done  = mod_done;
	assign status.scan_last = ({1'b0, idx_q} == (sz - 1'b1));
	assign status.out_free  = ~out_valid_q | out_ready;

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign found_seq    = found_seq_q;
	assign found_length = found_length_q;
	assign can_send     = can_send_q;
	assign all_acked    = all_acked_q;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_start |=> (used_q == '0))
		else $error("start left a slot marked");

	a_send_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_send |=> used_q[res_slot_q])
		else $error("sent slot not marked");

	a_lookup_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look_eval |=> (!res_hit_q || (res_fseq_q == item_seq_q)))
		else $error("lookup hit on a different sequence");

endmodule

@@ rtl/srsw_ctrl.sv @@
module srsw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  srsw_pkg::srsw_status_t status,
	output srsw_pkg::srsw_cmd_t    cmd
);
	import srsw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_MOD_WAIT,
		S_SEND,
		S_LOOK_RD,
		S_LOOK_EVAL,
		S_APPLY_START,
		S_SCAN_RD,
		S_SCAN_GO,
		S_SCAN_WAIT,
		S_SCAN_END,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid & in_ready;
		case (state_q)
			S_DISPATCH: begin
				cmd.mod_item  = status.kind inside {KIND_SEND, KIND_LOOKUP};
				cmd.scan_init = status.kind inside {KIND_LOWEST, KIND_RELEASE};
			end
			S_SEND:        cmd.do_send   = 1'b1;
			S_LOOK_RD:     cmd.rd_slot   = 1'b1;
			S_LOOK_EVAL:   cmd.look_eval = 1'b1;
			S_APPLY_START: cmd.do_start  = 1'b1;
			S_SCAN_RD:     cmd.rd_scan   = 1'b1;
			S_SCAN_GO:     cmd.mod_scan  = 1'b1;
			S_SCAN_WAIT:   cmd.scan_eval = status.mod_done;
			S_SCAN_END:    cmd.scan_end  = 1'b1;
			S_FINISH:      cmd.load_out  = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (status.kind)
						KIND_START:   state_q <= S_APPLY_START;
						KIND_SEND:    state_q <= S_MOD_WAIT;
						KIND_LOOKUP:  state_q <= S_MOD_WAIT;
						KIND_LOWEST:  state_q <= S_SCAN_RD;
						KIND_RELEASE: state_q <= S_SCAN_RD;
						default:      state_q <= S_FINISH;
					endcase
				end
				S_MOD_WAIT: begin
					if (status.mod_done) begin
						state_q <= (status.kind == KIND_SEND) ? S_SEND : S_LOOK_RD;
					end
				end
				S_SEND:        state_q <= S_FINISH;
				S_LOOK_RD:     state_q <= S_LOOK_EVAL;
				S_LOOK_EVAL:   state_q <= S_FINISH;
				S_APPLY_START: state_q <= S_FINISH;
				S_SCAN_RD:     state_q <= S_SCAN_GO;
				S_SCAN_GO:     state_q <= S_SCAN_WAIT;
				S_SCAN_WAIT: begin
					if (status.mod_done) begin
						state_q <= status.scan_last ? S_SCAN_END : S_SCAN_RD;
					end
				end
				S_SCAN_END:    state_q <= S_FINISH;
				S_FINISH: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:       state_q <= S_IDLE;
			endcase
		end
	end

	a_mod_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		status.mod_done |-> (state_q == S_MOD_WAIT || state_q == S_SCAN_WAIT))
		else $error("modulo finished outside a wait state");

endmodule
